@@ rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes for the periodic tick task table.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // request codes
    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_INSERT = 3'd1;
    localparam logic [2:0] FN_REMOVE = 3'd2;
    localparam logic [2:0] FN_RECONF = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;

    // result kinds
    localparam logic [2:0] KD_FIRE   = 3'd0;
    localparam logic [2:0] KD_INSERT = 3'd1;
    localparam logic [2:0] KD_REMOVE = 3'd2;
    localparam logic [2:0] KD_RECONF = 3'd3;
    localparam logic [2:0] KD_CLEAR  = 3'd4;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // fire results reported per tick
    localparam int MAX_RES = 16;

    // control broadcast from the sequencer to every slot cell
    typedef struct packed {
        logic        clear;
        logic        rm;
        logic        wr;
        logic        mod_init;
        logic        mod_step;
        logic        tbit;
        logic        eval;
        logic        load_free;
        logic        shift;
        logic [15:0] period;
        logic [15:0] offset;
        logic        enable;
        logic        run_once;
    } t_cell_ctl;

endpackage

@@ rtl/ptt_cell.sv @@
// ----------------------------------------------------------------------------
// ptt_cell
// One task slot: slot state, a bit-serial remainder unit and one stage of the
// flag shift chain.
// ----------------------------------------------------------------------------
module ptt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptt_pkg::t_cell_ctl i_ctl,
    input  logic              i_sel,
    input  logic              i_flag_next,
    output logic              o_flag,
    output logic              o_valid
);
    import ptt_pkg::*;

    logic        r_valid;
    logic        r_enable;
    logic        r_run_once;
    logic        r_flag;
    logic [15:0] r_period;
    logic [15:0] r_offset;
    logic [15:0] r_rem;

    logic [16:0] w_trial;
    logic        w_ge;
    logic [15:0] n_rem;
    logic        w_fire;

    // one restoring step of tick_count mod period, MSB first
    assign w_trial = {r_rem, i_ctl.tbit};
    assign w_ge    = w_trial >= {1'b0, r_period};
    assign n_rem   = w_ge ? 16'(w_trial - {1'b0, r_period}) : w_trial[15:0];

    assign w_fire = r_valid && r_enable && (r_period != 16'd0) && (r_rem == r_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_enable   <= 1'b0;
            r_run_once <= 1'b0;
            r_flag     <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_valid    <= 1'b0;
                r_enable   <= 1'b0;
                r_run_once <= 1'b0;
            end else if (i_ctl.rm && i_sel) begin
                r_valid    <= 1'b0;
                r_enable   <= 1'b0;
                r_run_once <= 1'b0;
            end else if (i_ctl.wr && i_sel) begin
                r_valid    <= 1'b1;
                r_enable   <= i_ctl.enable;
                r_run_once <= i_ctl.run_once;
            end else if (i_ctl.eval && w_fire && r_run_once) begin
                r_enable   <= 1'b0;
            end

            if (i_ctl.eval) begin
                r_flag <= w_fire;
            end else if (i_ctl.load_free) begin
                r_flag <= !r_valid;
            end else if (i_ctl.shift) begin
                r_flag <= i_flag_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_sel) begin
            r_period <= i_ctl.period;
            r_offset <= i_ctl.offset;
        end
        if (i_ctl.mod_init) begin
            r_rem <= 16'd0;
        end else if (i_ctl.mod_step) begin
            r_rem <= n_rem;
        end
    end

    assign o_flag  = r_flag;
    assign o_valid = r_valid;

endmodule

@@ rtl/periodic_tick_task_table.sv @@
// Tick: accept, then remainder steps (one per tick-count bit, MSB first), an
//   evaluate state, then a scan of up to SLOTS slots, one per cycle unless output stalls.
// Insert: accept, then walk the free-slot chain, one slot per cycle unless output stalls.
// Remove, reconfigure, clear: the acknowledge is registered in the accept cycle.
// One item in flight at a time. Reset empties the table and zeroes the tick
//   count at once; period and offset stores need no clearing pass.
// ----------------------------------------------------------------------------
// periodic_tick_task_table
// Table of periodic tasks driven by a tick, built as a chain of slot cells.
// ----------------------------------------------------------------------------
module periodic_tick_task_table #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [3:0]  i_slot,
    input  logic [15:0] i_period,
    input  logic [15:0] i_offset,
    input  logic        i_enable,
    input  logic        i_run_once,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_slot_res,
    output logic        o_status,
    output logic        o_last
);
    import ptt_pkg::*;

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [31:0]   r_tick;
    logic [4:0]    r_bit;
    logic [PW-1:0] r_pos;
    logic [3:0]    r_cnt;
    logic          r_ins;
    logic [15:0]   r_req_period;
    logic [15:0]   r_req_offset;
    logic          r_req_enable;
    logic          r_req_run_once;

    logic          r_ovalid;
    logic [2:0]    r_kind;
    logic [3:0]    r_slot;
    logic          r_status;
    logic          r_last;

    t_cell_ctl     w_ctl;
    logic [SLOTS-1:0] w_flag;
    logic [SLOTS-1:0] w_valid;
    logic [SLOTS-1:0] w_dec;
    logic [SLOTS-1:0] w_sel;
    logic [SLOTS-1:0] w_next;

    logic       w_out_free;
    logic       w_acc;
    logic       w_hit;
    logic       w_rest;
    logic       w_emit;
    logic [2:0] w_kind;
    logic [3:0] w_slot;
    logic       w_status;
    logic       w_last;
    logic       w_done;

    // ------------------------------------------------------------------
    // Slot cells: the flag of each cell shifts down towards cell 0, so the
    // sequencer takes each result from the head of the chain.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        assign w_dec[g]  = (32'(i_slot) == g);
        assign w_sel[g]  = (r_state == S_IDLE) ? w_dec[g] : (r_pos == PW'(g));
        assign w_next[g] = (g == SLOTS - 1) ? 1'b0 : w_flag[(g + 1) % SLOTS];

        ptt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_sel       (w_sel[g]),
            .i_flag_next (w_next[g]),
            .o_flag      (w_flag[g]),
            .o_valid     (w_valid[g])
        );
    end

    assign w_out_free = !r_ovalid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && w_out_free;
    assign w_acc      = i_valid && o_ready;

    // addressed slot exists and is valid (slots past SLOTS never decode)
    assign w_hit  = |(w_valid & w_dec);
    // any flag still pending behind the head of the chain
    assign w_rest = |(w_flag >> 1);

    // ------------------------------------------------------------------
    // Sequencer: drive the cell controls and pick the next result beat.
    // ------------------------------------------------------------------
    always_comb begin
        w_ctl          = '0;
        w_ctl.period   = (r_state == S_IDLE) ? i_period   : r_req_period;
        w_ctl.offset   = (r_state == S_IDLE) ? i_offset   : r_req_offset;
        w_ctl.enable   = (r_state == S_IDLE) ? i_enable   : r_req_enable;
        w_ctl.run_once = (r_state == S_IDLE) ? i_run_once : r_req_run_once;
        w_ctl.tbit     = r_tick[r_bit];

        w_emit   = 1'b0;
        w_kind   = KD_FIRE;
        w_slot   = 4'd0;
        w_status = ST_OK;
        w_last   = 1'b1;
        w_done   = 1'b0;
        n_state  = r_state;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_func)
                        FN_TICK: begin
                            w_ctl.mod_init = 1'b1;
                            n_state        = S_MOD;
                        end
                        FN_INSERT: begin
                            w_ctl.load_free = 1'b1;
                            n_state         = S_SCAN;
                        end
                        FN_REMOVE: begin
                            w_ctl.rm = w_hit;
                            w_emit   = 1'b1;
                            w_kind   = KD_REMOVE;
                            w_slot   = i_slot;
                            w_status = w_hit ? ST_OK : ST_FAIL;
                        end
                        FN_RECONF: begin
                            w_ctl.wr = w_hit;
                            w_emit   = 1'b1;
                            w_kind   = KD_RECONF;
                            w_slot   = i_slot;
                            w_status = w_hit ? ST_OK : ST_FAIL;
                        end
                        FN_CLEAR: begin
                            w_ctl.clear = 1'b1;
                            w_emit      = 1'b1;
                            w_kind      = KD_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOD: begin
                w_ctl.mod_step = 1'b1;
                if (r_bit == 5'd0) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                w_ctl.eval = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (w_out_free) begin
                    if (r_ins) begin
                        // head flag marks a free slot
                        if (w_flag[0]) begin
                            w_ctl.wr = 1'b1;
                            w_emit   = 1'b1;
                            w_kind   = KD_INSERT;
                            w_slot   = 4'(r_pos);
                            w_done   = 1'b1;
                        end else if (!w_rest) begin
                            w_emit   = 1'b1;
                            w_kind   = KD_INSERT;
                            w_status = ST_FAIL;
                            w_done   = 1'b1;
                        end
                    end else begin
                        // head flag marks a firing slot
                        if (w_flag[0]) begin
                            w_emit = 1'b1;
                            w_kind = KD_FIRE;
                            w_slot = 4'(r_pos);
                            w_last = !w_rest || (r_cnt == 4'(MAX_RES - 1));
                        end
                        w_done = !w_rest || (w_flag[0] && (r_cnt == 4'(MAX_RES - 1)));
                    end
                    w_ctl.shift = !w_done;
                    if (w_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_tick   <= 32'd0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            // clear restarts the count; each evaluated tick advances it
            if (w_ctl.clear) begin
                r_tick <= 32'd0;
            end else if (w_ctl.eval) begin
                r_tick <= r_tick + 32'd1;
            end
        end
    end

    // sequencing counters and held request fields
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_bit          <= 5'd31;
            r_pos          <= '0;
            r_ins          <= (i_func == FN_INSERT);
            r_req_period   <= i_period;
            r_req_offset   <= i_offset;
            r_req_enable   <= i_enable;
            r_req_run_once <= i_run_once;
        end else if (r_state == S_MOD) begin
            r_bit <= r_bit - 5'd1;
        end
        if (w_ctl.eval) begin
            r_pos <= '0;
            r_cnt <= 4'd0;
        end else if (w_ctl.shift) begin
            r_pos <= r_pos + PW'(1);
        end
        if (w_emit && (r_state == S_SCAN) && !r_ins) begin
            r_cnt <= r_cnt + 4'd1;
        end
        // hold the result beat until it is taken
        if (w_emit) begin
            r_kind   <= w_kind;
            r_slot   <= w_slot;
            r_status <= w_status;
            r_last   <= w_last;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_kind     = r_kind;
    assign o_slot_res = r_slot;
    assign o_status   = r_status;
    assign o_last     = r_last;

endmodule

@@ tb/periodic_tick_task_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_tick_task_table_checker
// Watches both channels of the task table, keeps a shadow of the slots and
// the tick counter, and compares every result beat against the prediction.
// ----------------------------------------------------------------------------
module periodic_tick_task_table_checker #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [2:0]  i_func,
    input  logic [3:0]  i_slot,
    input  logic [15:0] i_period,
    input  logic [15:0] i_offset,
    input  logic        i_enable,
    input  logic        i_run_once,
    // result channel
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_slot_res,
    input  logic        i_status,
    input  logic        i_last,
    // summary towards the top
    output int          o_fail_count,
    output int          o_pending,
    output int          o_beats,
    output int          o_fire_beats
);
    import ptt_pkg::*;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] slot;
        logic       status;
        logic       last;
    } t_task_result;

    logic [31:0]  tick_count;
    logic         slot_valid    [SLOTS];
    logic [15:0]  slot_period   [SLOTS];
    logic [15:0]  slot_offset   [SLOTS];
    logic         slot_enable   [SLOTS];
    logic         slot_run_once [SLOTS];

    t_task_result awaited_results [$];
    int           fail_count = 0;
    int           beats      = 0;
    int           fire_beats = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = awaited_results.size();
    assign o_beats      = beats;
    assign o_fire_beats = fire_beats;

    task automatic report_mismatch(input string msg);
        if (fail_count < 50)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic empty_table();
        for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i]    = 1'b0;
            slot_period[i]   = '0;
            slot_offset[i]   = '0;
            slot_enable[i]   = 1'b0;
            slot_run_once[i] = 1'b0;
        end
        tick_count = '0;
    endtask

    // Apply one accepted request to the shadow table and queue its results.
    task automatic table_step();
        t_task_result burst [$];
        t_task_result res;
        int           found;
        found = -1;
        case (i_func)
            FN_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_valid[i] && slot_enable[i] && slot_period[i] != 16'd0 &&
                        (tick_count % {16'd0, slot_period[i]}) == {16'd0, slot_offset[i]})
                    begin
                        // drop fires beyond the report limit, but still retire run-once
                        if (burst.size() < MAX_RES) begin
                            res = '{kind: KD_FIRE, slot: 4'(i), status: ST_OK, last: 1'b0};
                            burst = {burst, res};
                        end
                        if (slot_run_once[i])
                            slot_enable[i] = 1'b0;
                    end
                end
                tick_count = tick_count + 32'd1;
            end
            FN_INSERT: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (found < 0 && !slot_valid[i])
                        found = i;
                end
                if (found < 0) begin
                    res = '{kind: KD_INSERT, slot: 4'd0, status: ST_FAIL, last: 1'b1};
                end else begin
                    slot_valid[found]    = 1'b1;
                    slot_period[found]   = i_period;
                    slot_offset[found]   = i_offset;
                    slot_enable[found]   = i_enable;
                    slot_run_once[found] = i_run_once;
                    res = '{kind: KD_INSERT, slot: 4'(found), status: ST_OK, last: 1'b1};
                end
                burst = {burst, res};
            end
            FN_REMOVE: begin
                res = '{kind: KD_REMOVE, slot: i_slot, status: ST_FAIL, last: 1'b1};
                if (int'(i_slot) < SLOTS && slot_valid[i_slot]) begin
                    slot_valid[i_slot]    = 1'b0;
                    slot_enable[i_slot]   = 1'b0;
                    slot_run_once[i_slot] = 1'b0;
                    res.status = ST_OK;
                end
                burst = {burst, res};
            end
            FN_RECONF: begin
                res = '{kind: KD_RECONF, slot: i_slot, status: ST_FAIL, last: 1'b1};
                if (int'(i_slot) < SLOTS && slot_valid[i_slot]) begin
                    slot_period[i_slot]   = i_period;
                    slot_offset[i_slot]   = i_offset;
                    slot_enable[i_slot]   = i_enable;
                    slot_run_once[i_slot] = i_run_once;
                    res.status = ST_OK;
                end
                burst = {burst, res};
            end
            FN_CLEAR: begin
                empty_table();
                res = '{kind: KD_CLEAR, slot: 4'd0, status: ST_OK, last: 1'b1};
                burst = {burst, res};
            end
            default: ;
        endcase
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        awaited_results = {awaited_results, burst};
    endtask

    // Sample at the edge: inputs and outputs still hold their pre-edge values.
    always @(posedge i_clk) begin
        t_task_result want;
        if (!i_rst_n) begin
            empty_table();
            awaited_results.delete();
        end else begin
            // check the outgoing beat first, it can never belong to this edge's request
            if (i_res_valid && i_res_ready) begin
                beats++;
                if (i_kind == KD_FIRE)
                    fire_beats++;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat kind %0d slot %0d",
                                              i_kind, i_slot_res));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_kind !== want.kind)
                        report_mismatch($sformatf("kind want %0d got %0d",
                                                  want.kind, i_kind));
                    if (i_slot_res !== want.slot)
                        report_mismatch($sformatf("slot_res want %0d got %0d",
                                                  want.slot, i_slot_res));
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status want %0d got %0d",
                                                  want.status, i_status));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last want %0d got %0d",
                                                  want.last, i_last));
                end
            end
            if (i_req_valid && i_req_ready)
                table_step();
        end
    end

endmodule

@@ tb/periodic_tick_task_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_tick_task_table_tb
// Drives the task table with a directed opening and a long random phase of
// inserts, ticks, removes, reconfigures, clears and unused codes, with random
// gaps on both sides and one long receiver stall; the checker alongside judges every beat.
// ----------------------------------------------------------------------------
module periodic_tick_task_table_tb;
    import ptt_pkg::*;

    localparam int SLOTS         = 16;
    localparam int RANDOM_ITEMS  = 140;
    localparam int DRAIN_CYCLES  = 120;
    localparam int HOLD_CYCLES   = 400;    // long receiver stall
    localparam int HOLD_AFTER    = 40;     // beats seen before the long stall
    localparam int CYCLE_LIMIT   = 500_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_func;
    logic [3:0]  i_slot;
    logic [15:0] i_period;
    logic [15:0] i_offset;
    logic        i_enable;
    logic        i_run_once;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_kind;
    logic [3:0]  o_slot_res;
    logic        o_status;
    logic        o_last;

    int fail_count;
    int pending;
    int beats;
    int fire_beats;

    int cycle_count = 0;
    int sent        = 0;
    int n_ticks     = 0;
    int n_inserts   = 0;
    int n_removes   = 0;
    int n_reconfs   = 0;
    int n_clears    = 0;
    int n_unused    = 0;

    periodic_tick_task_table #(
        .SLOTS(SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_slot     (i_slot),
        .i_period   (i_period),
        .i_offset   (i_offset),
        .i_enable   (i_enable),
        .i_run_once (i_run_once),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_slot_res (o_slot_res),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    periodic_tick_task_table_checker #(
        .SLOTS(SLOTS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_func       (i_func),
        .i_slot       (i_slot),
        .i_period     (i_period),
        .i_offset     (i_offset),
        .i_enable     (i_enable),
        .i_run_once   (i_run_once),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_kind       (o_kind),
        .i_slot_res   (o_slot_res),
        .i_status     (o_status),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_beats      (beats),
        .o_fire_beats (fire_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop for a hung handshake or a lost result.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one request beat and hold it until the block takes it. Gaps are
    // random, except in every third stretch of 24 beats, which runs back to back.
    task automatic offer_request(input logic [2:0] f, input logic [3:0] s,
                                 input logic [15:0] p, input logic [15:0] o,
                                 input logic e, input logic r);
        int gap;
        gap = (((sent / 24) % 3) == 2) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func     <= f;
        i_slot     <= s;
        i_period   <= p;
        i_offset   <= o;
        i_enable   <= e;
        i_run_once <= r;
        i_valid    <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
        case (f)
            FN_TICK:   n_ticks++;
            FN_INSERT: n_inserts++;
            FN_REMOVE: n_removes++;
            FN_RECONF: n_reconfs++;
            FN_CLEAR:  n_clears++;
            default:   n_unused++;
        endcase
    endtask

    // Result side: random stalls per beat, a quiet stretch now and then, and
    // one long hold-off so the block fills and pushes back on its input.
    initial begin
        int  gap;
        int  seen;
        bit  held;
        seen = 0;
        held = 1'b0;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = (((seen / 30) % 3) == 1) ? 0 : $urandom_range(0, 19);
            if (!held && seen >= HOLD_AFTER) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            seen++;
        end
    end

    initial begin
        logic [2:0]  f;
        logic [3:0]  s;
        logic [15:0] p;
        logic [15:0] o;
        logic        e;
        logic        r;
        int          pick;
        int          counted;

        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_func     <= FN_TICK;
        i_slot     <= '0;
        i_period   <= '0;
        i_offset   <= '0;
        i_enable   <= 1'b0;
        i_run_once <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed opening ---
        // tick on an empty table: no beats, count still advances to 1
        offer_request(FN_TICK, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        // fill every slot: a zero period, an offset past its period, the widest
        // period, a disabled task, then period-1 tasks with alternating run-once
        offer_request(FN_INSERT, 4'd0, 16'd0, 16'd0, 1'b1, 1'b0);
        offer_request(FN_INSERT, 4'd0, 16'd3, 16'd5, 1'b1, 1'b0);
        offer_request(FN_INSERT, 4'd0, 16'hFFFF, 16'd1, 1'b1, 1'b1);
        offer_request(FN_INSERT, 4'd0, 16'd1, 16'd0, 1'b0, 1'b0);
        for (int i = 4; i < SLOTS; i++)
            offer_request(FN_INSERT, 4'hF, 16'd1, 16'd0, 1'b1, i[0]);
        // table full
        offer_request(FN_INSERT, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        // first tick fires everything live, second shows run-once retired
        offer_request(FN_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        offer_request(FN_TICK, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_request(FN_REMOVE, 4'd3, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_request(FN_REMOVE, 4'd3, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_request(FN_RECONF, 4'd3, 16'd2, 16'd1, 1'b1, 1'b0);
        offer_request(FN_RECONF, 4'd4, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        // unused codes are swallowed without a beat
        offer_request(3'd5, 4'd9, 16'h5A5A, 16'hA5A5, 1'b1, 1'b0);
        offer_request(3'd7, 4'd6, 16'hA5A5, 16'h5A5A, 1'b0, 1'b1);
        offer_request(FN_CLEAR, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);

        // --- random phase ---
        // Mostly small periods with offsets inside the period so tasks fire
        // often; the rest is full-width noise, zero periods and dead codes.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            s    = 4'($urandom_range(0, 15));
            e    = ($urandom_range(0, 9) != 0);
            r    = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                p = 16'($urandom);
                o = 16'($urandom);
                if ($urandom_range(0, 3) == 0)
                    p = '0;
            end else begin
                p = 16'($urandom_range(1, 6));
                o = 16'($urandom_range(0, int'(p) - 1));
            end
            if (pick < 45)
                f = FN_TICK;
            else if (pick < 63)
                f = FN_INSERT;
            else if (pick < 77)
                f = FN_REMOVE;
            else if (pick < 90)
                f = FN_RECONF;
            else if (pick < 93)
                f = FN_CLEAR;
            else
                f = 3'($urandom_range(5, 7));
            offer_request(f, s, p, o, e, r);
            if (f <= FN_CLEAR)
                counted++;
        end

        // --- drain ---
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d ticks, %0d inserts, %0d removes, %0d reconfigures,",
                 sent, n_ticks, n_inserts, n_removes, n_reconfs);
        $display("%0d clears, %0d dead codes; %0d result beats checked, %0d of them fires.",
                 n_clears, n_unused, beats, fire_beats);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
